FILE: sv/utf_enc_pkg.sv
package utf_enc_pkg;

  // Top six bits of a UTF-16 code unit that mark a surrogate.
  localparam logic [5:0] SurrogateHiTag = 6'b110110;
  localparam logic [5:0] SurrogateLoTag = 6'b110111;

  // Code point used for every unpaired surrogate.
  localparam logic [20:0] ReplacementChar = 21'h00FFFD;
  // Offset added to a combined surrogate pair.
  localparam logic [20:0] SupplementaryBase = 21'h010000;

  localparam int unsigned CountWidth = 17;
  localparam int unsigned MaxBytes = 6;

  typedef logic [20:0] code_point_t;

  // Per-string state that carries from one code unit to the next.
  typedef struct packed {
    logic                  pending_valid;
    logic [9:0]            pending_high;
    logic [CountWidth-1:0] byte_count;
    logic                  aborted;
  } str_state_t;

  // Everything one code unit produces, handed to the byte serialiser.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               count;
    logic                     ovf;
    logic                     done;
    logic [CountWidth-1:0]    base;
  } bundle_t;

  // Number of UTF-8 bytes needed for a code point.
  function automatic logic [2:0] enc_len(input code_point_t cp);
    logic [2:0] len;
    if (cp < 21'h000080) begin
      len = 3'd1;
    end else if (cp < 21'h000800) begin
      len = 3'd2;
    end else if (cp < 21'h010000) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  // UTF-8 bytes of a code point, first byte at index 0.
  function automatic logic [3:0][7:0] enc_bytes(input code_point_t cp);
    logic [3:0][7:0] b;
    b = '0;
    if (cp < 21'h000080) begin
      b[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h000800) begin
      b[0] = {3'b110, cp[10:6]};
      b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h010000) begin
      b[0] = {4'b1110, cp[15:12]};
      b[1] = {2'b10, cp[11:6]};
      b[2] = {2'b10, cp[5:0]};
    end else begin
      b[0] = {5'b11110, cp[20:18]};
      b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]};
      b[3] = {2'b10, cp[5:0]};
    end
    return b;
  endfunction

endpackage

FILE: sv/utf_enc_unit_if.sv
interface utf_enc_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        string_end;

  modport source (output valid, output code_unit, output string_end, input ready);
  modport sink (input valid, input code_unit, input string_end, output ready);
endinterface

FILE: sv/utf_enc_byte_if.sv
interface utf_enc_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        string_done;
  logic        overflow;
  logic [16:0] total_bytes;

  modport source (
    output valid, output out_byte, output run_last, output string_done,
    output overflow, output total_bytes, input ready
  );
  modport sink (
    input valid, input out_byte, input run_last, input string_done,
    input overflow, input total_bytes, output ready
  );
endinterface

FILE: sv/utf_enc_decode.sv
module utf_enc_decode (
  input  logic [15:0]             code_unit,
  input  logic                    string_end,
  input  utf_enc_pkg::str_state_t st,
  input  logic [16:0]             cap,
  output utf_enc_pkg::bundle_t    bnd,
  output utf_enc_pkg::str_state_t st_next
);

  logic                     is_hi;
  logic                     is_lo;
  logic                     new_valid;
  utf_enc_pkg::code_point_t new_cp;
  utf_enc_pkg::code_point_t pair_cp;
  logic                     c0_valid;
  logic                     c1_valid;
  utf_enc_pkg::code_point_t c0;
  utf_enc_pkg::code_point_t c1;
  logic [2:0]               len0;
  logic [2:0]               len1;
  logic [3:0][7:0]          b0;
  logic [3:0][7:0]          b1;
  logic                     fit0;
  logic                     fit1;
  logic                     emit0;
  logic                     emit1;
  logic                     abort;
  logic                     hold;
  logic                     aborted_after;
  logic [2:0]               nbytes;

  assign is_hi = (code_unit[15:10] == utf_enc_pkg::SurrogateHiTag);
  assign is_lo = (code_unit[15:10] == utf_enc_pkg::SurrogateLoTag);

  // The unit on its own: a high surrogate that does not end the string is held.
  assign new_valid = !(is_hi && !string_end);
  assign new_cp    = (is_hi || is_lo) ? utf_enc_pkg::ReplacementChar : {5'd0, code_unit};
  assign pair_cp   = utf_enc_pkg::SupplementaryBase
                   + {1'b0, st.pending_high, code_unit[9:0]};

  always_comb begin
    if (st.pending_valid) begin
      c0_valid = 1'b1;
      c0       = is_lo ? pair_cp : utf_enc_pkg::ReplacementChar;
      c1_valid = !is_lo && new_valid;
      c1       = new_cp;
    end else begin
      c0_valid = new_valid;
      c0       = new_cp;
      c1_valid = 1'b0;
      c1       = new_cp;
    end
  end

  assign hold = !st.aborted && !(st.pending_valid && is_lo) && is_hi && !string_end;

  assign len0 = utf_enc_pkg::enc_len(c0);
  assign len1 = utf_enc_pkg::enc_len(c1);
  assign b0   = utf_enc_pkg::enc_bytes(c0);
  assign b1   = utf_enc_pkg::enc_bytes(c1);

  assign fit0 = (18'(st.byte_count) + 18'(len0)) <= 18'(cap);
  assign fit1 = (18'(st.byte_count) + 18'(len0) + 18'(len1)) <= 18'(cap);

  // A character is written whole or not at all; the first miss aborts the string.
  assign emit0 = !st.aborted && c0_valid && fit0;
  assign emit1 = emit0 && c1_valid && fit1;
  assign abort = !st.aborted && ((c0_valid && !fit0) || (emit0 && c1_valid && !fit1));
  assign aborted_after = st.aborted || abort;

  assign nbytes = (emit0 ? len0 : 3'd0) + (emit1 ? len1 : 3'd0);

  always_comb begin
    int j;
    j = 0;
    for (int k = 0; k < utf_enc_pkg::MaxBytes; k++) begin
      j = k - int'(len0);
      if (k < int'(len0)) begin
        bnd.bytes[k] = b0[2'(k)];
      end else if (j < 4) begin
        bnd.bytes[k] = b1[2'(j)];
      end else begin
        bnd.bytes[k] = 8'h00;
      end
    end
    bnd.ovf   = string_end && aborted_after;
    bnd.count = nbytes + {2'd0, string_end && aborted_after};
    bnd.done  = string_end;
    bnd.base  = st.byte_count;
  end

  always_comb begin
    if (string_end) begin
      st_next = '0;
    end else begin
      st_next.pending_valid = hold && !abort;
      st_next.pending_high  = (hold && !abort) ? code_unit[9:0] : 10'd0;
      st_next.byte_count    = st.byte_count + 17'(nbytes);
      st_next.aborted       = aborted_after;
    end
  end

endmodule

FILE: sv/utf_enc_emit.sv
module utf_enc_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  utf_enc_pkg::bundle_t  bnd_in,
  output logic                  slot_free,
  utf_enc_byte_if.source        utf8
);

  logic                 bv;
  utf_enc_pkg::bundle_t bnd;
  logic [2:0]           idx;
  logic                 out_adv;
  logic                 take;
  logic                 last;
  logic                 is_ovf;

  assign out_adv   = !utf8.valid || utf8.ready;
  assign take      = bv && out_adv;
  assign last      = (idx == bnd.count - 3'd1);
  assign is_ovf    = bnd.ovf && last;
  assign slot_free = !bv || (take && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      bv  <= 1'b0;
      idx <= '0;
    end else if (load) begin
      bv  <= 1'b1;
      idx <= '0;
    end else if (take && last) begin
      bv <= 1'b0;
    end else if (take) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bnd <= bnd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      utf8.valid <= 1'b0;
    end else if (take) begin
      utf8.valid <= 1'b1;
    end else if (utf8.ready) begin
      utf8.valid <= 1'b0;
    end
  end

  // The overflow beat carries a zero byte and the count before the overflow.
  always_ff @(posedge clk) begin
    if (take) begin
      utf8.out_byte    <= is_ovf ? 8'h00 : bnd.bytes[idx];
      utf8.run_last    <= last;
      utf8.string_done <= last && bnd.done;
      utf8.overflow    <= is_ovf;
      utf8.total_bytes <= bnd.base + 17'(idx) + (is_ovf ? 17'd0 : 17'd1);
    end
  end

endmodule

FILE: sv/utf16_to_utf8_encoder.sv
// Channel  Direction  Beat payload
// -------  ---------  ------------------------------------------------------
// units    in         code_unit[15:0], string_end
// utf8     out        out_byte[7:0], run_last, string_done, overflow,
//                     total_bytes[16:0]
// cfg      in         cfg_we, cfg_wdata[16:0] (output capacity)
//
// A code unit passes the input, bundle and output registers before its first
// output beat. The byte serialiser sends one byte per cycle unless the output
// stalls, so a unit holds it until its results (one to six) are out; unstalled
// single-byte units flow one per cycle. Reset clears all string state and sets
// the capacity to 65536. Either side may stall at any time: the output register
// holds its beat and the input register fills and then drops ready.
module utf16_to_utf8_encoder #(
  parameter int unsigned MAX_BYTES = 65536
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [16:0]     cfg_wdata,
  utf_enc_unit_if.sink    units,
  utf_enc_byte_if.source  utf8
);

  // The capacity in force never exceeds MAX_BYTES. The register is only 17 bits
  // wide, so any larger limit leaves the written value untouched.
  localparam logic [16:0] MaxCap = (MAX_BYTES > 131071) ? 17'h1FFFF : 17'(MAX_BYTES);

  logic [16:0]             capacity;
  logic [16:0]             cap_eff;

  // Input register: one code unit waiting for the decoder.
  logic                    in_valid;
  logic [15:0]             unit_q;
  logic                    end_q;

  utf_enc_pkg::str_state_t st;
  utf_enc_pkg::str_state_t st_next;
  utf_enc_pkg::bundle_t    dec_bnd;

  logic                    slot_free;
  logic                    consume;
  logic                    load;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 17'h10000;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  assign cap_eff = (capacity > MaxCap) ? MaxCap : capacity;

  // The decoder works on the held unit as soon as the serialiser can take its
  // bytes. The string state moves on in the same cycle, so the next unit sees
  // it at once. A unit with no bytes (a held high surrogate, or a unit after an
  // abort that does not end the string) just updates the state.
  assign consume     = in_valid && slot_free;
  assign load        = consume && (dec_bnd.count != 3'd0);
  assign units.ready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (units.valid && units.ready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (units.valid && units.ready) begin
      unit_q <= units.code_unit;
      end_q  <= units.string_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (consume) begin
      st <= st_next;
    end
  end

  utf_enc_decode u_decode (
    .code_unit  (unit_q),
    .string_end (end_q),
    .st         (st),
    .cap        (cap_eff),
    .bnd        (dec_bnd),
    .st_next    (st_next)
  );

  utf_enc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .bnd_in    (dec_bnd),
    .slot_free (slot_free),
    .utf8      (utf8)
  );

  // An abort drops any held high surrogate.
  a_no_pending_when_aborted : assert property (
    @(posedge clk) disable iff (rst) !(st.pending_valid && st.aborted)
  ) else $error("held surrogate survives an aborted string");

  // The overflow report is always the single closing beat of its string.
  a_overflow_closes_string : assert property (
    @(posedge clk) disable iff (rst)
    utf8.valid && utf8.overflow |->
      utf8.run_last && utf8.string_done && (utf8.out_byte == 8'h00)
  ) else $error("overflow beat does not close the string");

  // Once the end of a string is decoded the next unit starts from clean state.
  a_state_cleared_at_end : assert property (
    @(posedge clk) disable iff (rst)
    consume && end_q |=>
      !st.pending_valid && !st.aborted && (st.byte_count == 17'd0)
  ) else $error("string state not cleared after string end");

endmodule

FILE: tb/tb_top.sv
module tb_top;

  // The block is built with its default ceiling, so the capacity in force is
  // never above this many bytes per string.
  localparam int unsigned CapCeiling = 65536;
  localparam logic [16:0] CapFull = 17'd65536;
  localparam logic [16:0] CapWidest = 17'h1FFFF;
  // A unit that gives no byte may still sit in the pipeline when the last
  // owed byte has arrived, so configuration waits this many cycles more.
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned UnitsPerPhase = 15;

  // One beat on the UTF-8 side, in the order the block presents its fields.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        run_last;
    logic        string_done;
    logic        overflow;
    logic [16:0] total_bytes;
  } utf8_beat_t;

  // One row of the hand-written opening sequence. Where typed_n is zero the
  // bytes come from the encoder model; otherwise typed_seq holds the bytes of
  // a whole one-unit string, first byte in the top octet. A typed overflow
  // row owes a single overflow beat instead.
  typedef struct packed {
    logic [16:0] cap;
    logic [15:0] cu;
    logic        last;
    logic [2:0]  typed_n;
    logic        typed_ovf;
    logic [31:0] typed_seq;
  } unit_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [16:0] cfg_wdata;

  utf_enc_unit_if unit_ch ();
  utf_enc_byte_if byte_ch ();

  utf16_to_utf8_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .units     (unit_ch),
    .utf8      (byte_ch)
  );

  // Period of four units, two high and two low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Encoder model state: the capacity register and the per-string state.
  logic [16:0] capacity_reg;
  bit          held_valid;
  logic [9:0]  held_high;
  int unsigned str_bytes;
  bit          str_aborted;

  // UTF-8 beats the block owes, oldest first.
  utf8_beat_t  due_bytes[$];

  // When set, neither side idles, giving a stretch at full rate.
  bit          steady;
  int unsigned cycles;
  int unsigned errors;
  int unsigned units_sent;
  int unsigned strings_sent;
  int unsigned bytes_seen;
  int unsigned overflows_seen;

  unit_row_t unit_table [25] = '{
    // Single-unit strings at the edges of each UTF-8 length.
    '{CapFull, 16'h0000, 1'b1, 3'd1, 1'b0, 32'h00000000},
    '{CapFull, 16'h007F, 1'b1, 3'd1, 1'b0, 32'h7F000000},
    '{CapFull, 16'h0080, 1'b1, 3'd2, 1'b0, 32'hC2800000},
    '{CapFull, 16'h07FF, 1'b1, 3'd2, 1'b0, 32'hDFBF0000},
    '{CapFull, 16'h0800, 1'b1, 3'd3, 1'b0, 32'hE0A08000},
    '{CapFull, 16'hFFFF, 1'b1, 3'd3, 1'b0, 32'hEFBFBF00},
    // Lowest and highest surrogate pairs.
    '{CapFull, 16'hD800, 1'b0, 3'd0, 1'b0, 32'h0},
    '{CapFull, 16'hDC00, 1'b1, 3'd0, 1'b0, 32'h0},
    '{CapFull, 16'hDBFF, 1'b0, 3'd0, 1'b0, 32'h0},
    '{CapFull, 16'hDFFF, 1'b1, 3'd0, 1'b0, 32'h0},
    // A lone low surrogate, and a high surrogate that ends the string, both
    // turn into the replacement character.
    '{CapFull, 16'hDC00, 1'b1, 3'd3, 1'b0, 32'hEFBFBD00},
    '{CapFull, 16'hDBFF, 1'b1, 3'd3, 1'b0, 32'hEFBFBD00},
    // High surrogate followed by a plain character.
    '{CapFull, 16'hD83D, 1'b0, 3'd0, 1'b0, 32'h0},
    '{CapFull, 16'h0041, 1'b1, 3'd0, 1'b0, 32'h0},
    // High surrogate followed by a three-byte character: six beats.
    '{CapFull, 16'hD800, 1'b0, 3'd0, 1'b0, 32'h0},
    '{CapFull, 16'hFFFF, 1'b1, 3'd0, 1'b0, 32'h0},
    // Two high surrogates, the second ending the string: six beats.
    '{CapFull, 16'hD800, 1'b0, 3'd0, 1'b0, 32'h0},
    '{CapFull, 16'hD801, 1'b1, 3'd0, 1'b0, 32'h0},
    // With no capacity the first character overflows.
    '{17'd0,   16'h0041, 1'b1, 3'd1, 1'b1, 32'h00000000},
    // Overflow part way through a unit: the replacement character fits, the
    // character after it does not.
    '{17'd5,   16'h0041, 1'b0, 3'd0, 1'b0, 32'h0},
    '{17'd5,   16'hD800, 1'b0, 3'd0, 1'b0, 32'h0},
    '{17'd5,   16'hFFFF, 1'b1, 3'd0, 1'b0, 32'h0},
    // A unit that fits, then overflow on a unit that is not the last, then the
    // string end, which is dropped and reports the overflow alone.
    '{17'd5,   16'h0800, 1'b0, 3'd0, 1'b0, 32'h0},
    '{17'd5,   16'h0800, 1'b0, 3'd0, 1'b0, 32'h0},
    '{17'd5,   16'h0042, 1'b1, 3'd0, 1'b0, 32'h0}
  };

  // Works out the beats one accepted code unit causes and advances the
  // string state, exactly as the block is meant to.
  task automatic encode_unit(input logic [15:0] cu, input bit last,
                             ref utf8_beat_t beats[$]);
    utf_enc_pkg::code_point_t chars[$];
    utf_enc_pkg::code_point_t cp;
    int unsigned cap;
    int unsigned n;
    int unsigned i;
    int unsigned k;
    bit          paired;
    logic [7:0]  lead_mark;
    utf8_beat_t  b;
    beats = {};
    cap = (capacity_reg > CapCeiling) ? CapCeiling : capacity_reg;
    if (!str_aborted) begin
      paired = 1'b0;
      // A held high surrogate either pairs with this unit or is replaced.
      if (held_valid) begin
        held_valid = 1'b0;
        if (cu[15:10] == utf_enc_pkg::SurrogateLoTag) begin
          chars.push_back(utf_enc_pkg::SupplementaryBase + {held_high, cu[9:0]});
          paired = 1'b1;
        end else begin
          chars.push_back(utf_enc_pkg::ReplacementChar);
        end
        held_high = '0;
      end
      if (!paired) begin
        if (cu[15:10] == utf_enc_pkg::SurrogateHiTag) begin
          if (last) begin
            chars.push_back(utf_enc_pkg::ReplacementChar);
          end else begin
            held_valid = 1'b1;
            held_high = cu[9:0];
          end
        end else if (cu[15:10] == utf_enc_pkg::SurrogateLoTag) begin
          chars.push_back(utf_enc_pkg::ReplacementChar);
        end else begin
          chars.push_back({5'd0, cu});
        end
      end
      // Each character goes out whole or, if it would pass the capacity, not
      // at all, and the string is then aborted.
      for (i = 0; i < chars.size() && !str_aborted; i++) begin
        cp = chars[i];
        n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
        if (str_bytes + n > cap) begin
          str_aborted = 1'b1;
          held_valid = 1'b0;
          held_high = '0;
        end else begin
          lead_mark = 8'(8'hF0 << (4 - n));
          for (k = 0; k < n; k++) begin
            str_bytes++;
            b = '0;
            if (n == 1) begin
              b.out_byte = cp[7:0];
            end else if (k == 0) begin
              b.out_byte = lead_mark | 8'(cp >> (6 * (n - 1)));
            end else begin
              b.out_byte = 8'h80 | (8'(cp >> (6 * (n - 1 - k))) & 8'h3F);
            end
            b.total_bytes = str_bytes[16:0];
            beats.push_back(b);
          end
        end
      end
    end
    if (last) begin
      if (str_aborted) begin
        b = '0;
        b.overflow = 1'b1;
        b.total_bytes = str_bytes[16:0];
        beats.push_back(b);
      end
      beats[beats.size() - 1].string_done = 1'b1;
      held_valid = 1'b0;
      held_high = '0;
      str_bytes = 0;
      str_aborted = 1'b0;
    end
    if (beats.size() > 0) begin
      beats[beats.size() - 1].run_last = 1'b1;
    end
  endtask

  // Offers one code unit, starting at a falling edge and returning at the
  // falling edge after its beat. Typed beats, if given, replace the model's
  // prediction, though the model still sees the unit to keep its state.
  task automatic send_unit(input logic [15:0] cu, input bit last,
                           ref utf8_beat_t typed[$]);
    utf8_beat_t beats[$];
    while (!steady && $urandom_range(0, 99) < 26) begin
      unit_ch.valid <= 1'b0;
      @(negedge clk);
    end
    unit_ch.valid <= 1'b1;
    unit_ch.code_unit <= cu;
    unit_ch.string_end <= last;
    do @(posedge clk); while (!unit_ch.ready);
    encode_unit(cu, last, beats);
    if (typed.size() > 0) begin
      beats = typed;
    end
    foreach (beats[j]) due_bytes.push_back(beats[j]);
    units_sent++;
    if (last) strings_sent++;
    @(negedge clk);
  endtask

  // Lets the block run dry and then writes the capacity. Every call is also a
  // point where the sender holds off until all owed bytes have come back.
  task automatic write_capacity(input logic [16:0] value);
    unit_ch.valid <= 1'b0;
    while (due_bytes.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    capacity_reg = value;
  endtask

  // Builds a string of one to six characters, mostly well formed, with a
  // share of unpaired surrogates and raw noise, and sends it.
  task automatic send_random_string(ref int unsigned sent);
    logic [15:0] text[$];
    utf8_beat_t  none[$];
    int unsigned want;
    int unsigned pick;
    want = $urandom_range(1, 6);
    while (text.size() < want) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        text.push_back(16'($urandom_range(0, 16'h7F)));
      end else if (pick < 40) begin
        text.push_back(16'($urandom_range(16'h80, 16'h7FF)));
      end else if (pick < 55) begin
        if ($urandom_range(0, 1) == 0) begin
          text.push_back(16'($urandom_range(16'h800, 16'hD7FF)));
        end else begin
          text.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
        end
      end else if (pick < 80) begin
        text.push_back({utf_enc_pkg::SurrogateHiTag, 10'($urandom_range(0, 1023))});
        text.push_back({utf_enc_pkg::SurrogateLoTag, 10'($urandom_range(0, 1023))});
      end else if (pick < 85) begin
        text.push_back({utf_enc_pkg::SurrogateLoTag, 10'($urandom_range(0, 1023))});
      end else if (pick < 90) begin
        text.push_back({utf_enc_pkg::SurrogateHiTag, 10'($urandom_range(0, 1023))});
      end else begin
        text.push_back(16'($urandom_range(0, 16'hFFFF)));
      end
    end
    foreach (text[j]) send_unit(text[j], j == text.size() - 1, none);
    sent += text.size();
  endtask

  // The receiver drops ready at random, except in the steady stretch.
  always @(negedge clk) begin
    byte_ch.ready <= steady || ($urandom_range(0, 99) >= 26);
  end

  // Every accepted beat is checked against the oldest owed beat.
  always @(posedge clk) begin
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      bytes_seen++;
      if (byte_ch.overflow) overflows_seen++;
      if (due_bytes.size() == 0) begin
        errors++;
        $error("unexpected beat: out_byte %h total_bytes %0d", byte_ch.out_byte,
               byte_ch.total_bytes);
      end else begin
        if (byte_ch.out_byte !== due_bytes[0].out_byte) begin
          errors++;
          $error("out_byte: expected %h, got %h", due_bytes[0].out_byte,
                 byte_ch.out_byte);
        end
        if (byte_ch.run_last !== due_bytes[0].run_last) begin
          errors++;
          $error("run_last: expected %b, got %b", due_bytes[0].run_last,
                 byte_ch.run_last);
        end
        if (byte_ch.string_done !== due_bytes[0].string_done) begin
          errors++;
          $error("string_done: expected %b, got %b", due_bytes[0].string_done,
                 byte_ch.string_done);
        end
        if (byte_ch.overflow !== due_bytes[0].overflow) begin
          errors++;
          $error("overflow: expected %b, got %b", due_bytes[0].overflow,
                 byte_ch.overflow);
        end
        if (byte_ch.total_bytes !== due_bytes[0].total_bytes) begin
          errors++;
          $error("total_bytes: expected %0d, got %0d", due_bytes[0].total_bytes,
                 byte_ch.total_bytes);
        end
        void'(due_bytes.pop_front());
      end
    end
  end

  always @(posedge clk) cycles++;

  // Watchdog: a hung handshake or a beat that never arrives ends up here.
  initial begin
    while (cycles < CycleLimit) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    unit_row_t   row;
    utf8_beat_t  typed[$];
    utf8_beat_t  b;
    logic [16:0] phase_cap[5];
    int unsigned sent;
    int unsigned k;
    int unsigned p;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    unit_ch.valid = 1'b0;
    unit_ch.code_unit = '0;
    unit_ch.string_end = 1'b0;
    byte_ch.ready = 1'b0;
    steady = 1'b0;
    capacity_reg = CapFull;
    held_valid = 1'b0;
    held_high = '0;
    str_bytes = 0;
    str_aborted = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Opening sequence from the table, changing the capacity where a row
    // asks for a different one.
    foreach (unit_table[r]) begin
      row = unit_table[r];
      if (row.cap != capacity_reg) write_capacity(row.cap);
      typed = {};
      for (k = 0; k < row.typed_n; k++) begin
        b = '0;
        b.out_byte = row.typed_seq[31 - 8 * k -: 8];
        b.overflow = row.typed_ovf;
        b.total_bytes = row.typed_ovf ? 17'd0 : 17'(k + 1);
        b.run_last = (k == row.typed_n - 1);
        b.string_done = (k == row.typed_n - 1);
        typed.push_back(b);
      end
      send_unit(row.cu, row.last, typed);
    end

    // Random strings under a run of capacities: a tight one, none at all, the
    // widest the register holds (clamped by the block), a second tight one
    // and the reset value. The third phase runs with no idling on either side.
    phase_cap[0] = 17'($urandom_range(1, 12));
    phase_cap[1] = 17'd0;
    phase_cap[2] = CapWidest;
    phase_cap[3] = 17'($urandom_range(3, 24));
    phase_cap[4] = CapFull;
    for (p = 0; p < 5; p++) begin
      write_capacity(phase_cap[p]);
      steady = (p == 2);
      sent = 0;
      while (sent < UnitsPerPhase) send_random_string(sent);
    end
    steady = 1'b0;

    unit_ch.valid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Encoded %0d code units in %0d strings under eight capacity settings.",
             units_sent, strings_sent);
    $display("Checked %0d UTF-8 beats, %0d of them overflow reports.", bytes_seen,
             overflows_seen);
    if (errors == 0 && due_bytes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
